[hdl/dad_pkg.sv]
// package for the date add days unit: microcode types, program table and calendar helpers
`default_nettype none

package dad_pkg;

    localparam int YEAR_MAX_DEF    = 9999;
    localparam int OFFSET_BITS_DEF = 21;

    localparam int PC_W = 3;

    localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
    localparam logic [PC_W-1:0] PC_MOD400 = 3'd1;
    localparam logic [PC_W-1:0] PC_DOY    = 3'd2;
    localparam logic [PC_W-1:0] PC_ADDOFS = 3'd3;
    localparam logic [PC_W-1:0] PC_YSTEP  = 3'd4;
    localparam logic [PC_W-1:0] PC_FLAGS  = 3'd5;
    localparam logic [PC_W-1:0] PC_MSTEP  = 3'd6;
    localparam logic [PC_W-1:0] PC_EMIT   = 3'd7;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_SUB400,
        OP_DOY,
        OP_ADDOFS,
        OP_YSTEP,
        OP_FLAGS,
        OP_MSTEP,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NOACC,
        C_GE400,
        C_YMOVE,
        C_BAD,
        C_MMOVE,
        C_OBUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  tgt;
    } t_uword;

    // program: jump to tgt when cond holds, else fall through to the next step
    function automatic t_uword dad_ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            PC_WAIT:   w = '{op: OP_LOAD,   cond: C_NOACC, tgt: PC_WAIT};
            PC_MOD400: w = '{op: OP_SUB400, cond: C_GE400, tgt: PC_MOD400};
            PC_DOY:    w = '{op: OP_DOY,    cond: C_NEVER, tgt: PC_WAIT};
            PC_ADDOFS: w = '{op: OP_ADDOFS, cond: C_NEVER, tgt: PC_WAIT};
            PC_YSTEP:  w = '{op: OP_YSTEP,  cond: C_YMOVE, tgt: PC_YSTEP};
            PC_FLAGS:  w = '{op: OP_FLAGS,  cond: C_BAD,   tgt: PC_EMIT};
            PC_MSTEP:  w = '{op: OP_MSTEP,  cond: C_MMOVE, tgt: PC_MSTEP};
            PC_EMIT:   w = '{op: OP_EMIT,   cond: C_OBUSY, tgt: PC_EMIT};
            default:   w = '{op: OP_LOAD,   cond: C_NOACC, tgt: PC_WAIT};
        endcase
        return w;
    endfunction

    // leap rule on the year modulo 400
    function automatic logic dad_leap(input logic [8:0] c);
        return (c[1:0] == 2'd0) && !((c == 9'd100) || (c == 9'd200) || (c == 9'd300));
    endfunction

    function automatic logic [8:0] dad_dbm(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            default: d = 9'd334;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] dad_mlen(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        case (m)
            4'd1:                   d = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
            default:                d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[hdl/date_add_days_unit.sv]
// date add days unit: gregorian date plus signed day offset, microcoded sequencer
//
// input channel: i_valid / o_stall carry start year, month, day and a signed day
// offset; an item is taken on a rising edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall carry the result date and the overflow flag.
// one item is worked at a time by an eight-step program in a read-only table.
// the step counter walks: load, year modulo 400 (400 years taken off per step),
// day of year, add offset, then one step per whole year crossed, a range check,
// then, unless that check fails, one step per month crossed and the output write.
// a new item is taken as soon as the previous result sits in the output register,
// even while that result is still stalled.
// a result outside years 1 to YEAR_MAX sets o_year_overflow and clamps the date.
// reset (synchronous, active low) returns the sequencer to its wait step and
// empties the output register.
// while i_stall is high a waiting result holds, and a sequencer that reaches its
// output step waits there.
`default_nettype none

module date_add_days_unit
    import dad_pkg::*;
#(
    parameter int YEAR_MAX    = YEAR_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [13:0]                   i_start_year,
    input  wire logic [3:0]                    i_start_month,
    input  wire logic [4:0]                    i_start_day,
    input  wire logic signed [OFFSET_BITS-1:0] i_day_offset,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [13:0]                        o_result_year,
    output logic [3:0]                         o_result_month,
    output logic [4:0]                         o_result_day,
    output logic                               o_year_overflow
);

    localparam int YLIM = (YEAR_MAX + 2 > 16384) ? YEAR_MAX + 2 : 16384;
    localparam int YW   = $clog2(YLIM);
    localparam int TW   = ((OFFSET_BITS > 10) ? OFFSET_BITS : 10) + 2;

    localparam logic [YW-1:0] YMAX_Y  = YW'(YEAR_MAX);
    localparam logic [13:0]   YMAX_14 = 14'(YEAR_MAX);

    logic [PC_W-1:0]                r_pc, n_pc;
    logic [YW-1:0]                  r_year, n_year;
    logic [YW-1:0]                  r_c400, n_c400;
    logic [3:0]                     r_mon, n_mon;
    logic [4:0]                     r_day, n_day;
    logic signed [OFFSET_BITS-1:0]  r_ofs, n_ofs;
    logic signed [TW-1:0]           r_t, n_t;
    logic                           r_under, n_under;
    logic                           r_over, n_over;
    logic                           r_o_valid, n_o_valid;
    logic [13:0]                    r_o_year, n_o_year;
    logic [3:0]                     r_o_month, n_o_month;
    logic [4:0]                     r_o_day, n_o_day;
    logic                           r_o_ovf, n_o_ovf;

    t_uword                         uw;
    logic                           accept;
    logic                           jump;
    logic                           t_neg;
    logic [8:0]                     c9, c_prev, c_next;
    logic                           leap_cur, leap_prev;
    logic signed [TW-1:0]           ylen, ylen_prev, mlen_s;
    logic                           go_dn, go_up, y_move;
    logic                           under_c, over_c;
    logic                           m_move;
    logic                           o_busy;
    logic [3:0]                     mon_idx;

    assign uw        = dad_ucode(r_pc);
    assign o_stall   = (r_pc != PC_WAIT);
    assign accept    = i_valid && !o_stall;
    assign o_busy    = r_o_valid && i_stall;

    assign t_neg     = r_t[TW-1];
    assign c9        = r_c400[8:0];
    assign c_prev    = (c9 == 9'd0) ? 9'd399 : c9 - 9'd1;
    assign c_next    = (c9 == 9'd399) ? 9'd0 : c9 + 9'd1;
    assign leap_cur  = dad_leap(c9);
    assign leap_prev = dad_leap(c_prev);
    assign ylen      = TW'(365) + TW'(leap_cur);
    assign ylen_prev = TW'(365) + TW'(leap_prev);
    assign mlen_s    = TW'(dad_mlen(r_mon, leap_cur));

    assign go_dn     = t_neg && (r_year != '0);
    assign go_up     = !t_neg && (r_t >= ylen) && (r_year <= YMAX_Y);
    assign y_move    = go_dn || go_up;
    assign under_c   = t_neg || (r_year == '0);
    assign over_c    = !under_c && (r_year > YMAX_Y);
    assign m_move    = (r_mon < 4'd11) && (r_t >= mlen_s);

    assign mon_idx   = (i_start_month == 4'd0) ? 4'd0 :
                       (i_start_month > 4'd12) ? 4'd11 : i_start_month - 4'd1;

    always_comb begin
        unique case (uw.cond)
            C_NEVER: jump = 1'b0;
            C_NOACC: jump = !accept;
            C_GE400: jump = (r_c400 >= YW'(400));
            C_YMOVE: jump = y_move;
            C_BAD:   jump = under_c || over_c;
            C_MMOVE: jump = m_move;
            C_OBUSY: jump = o_busy;
            default: jump = 1'b0;
        endcase
        n_pc = jump ? uw.tgt : r_pc + 3'd1;
    end

    always_comb begin
        n_year    = r_year;
        n_c400    = r_c400;
        n_mon     = r_mon;
        n_day     = r_day;
        n_ofs     = r_ofs;
        n_t       = r_t;
        n_under   = r_under;
        n_over    = r_over;
        n_o_valid = r_o_valid && i_stall;
        n_o_year  = r_o_year;
        n_o_month = r_o_month;
        n_o_day   = r_o_day;
        n_o_ovf   = r_o_ovf;
        unique case (uw.op)
            OP_LOAD: begin
                if (accept) begin
                    n_year = YW'(i_start_year);
                    n_c400 = YW'(i_start_year);
                    n_mon  = mon_idx;
                    n_day  = i_start_day;
                    n_ofs  = i_day_offset;
                end
            end
            OP_SUB400: begin
                if (r_c400 >= YW'(400)) begin
                    n_c400 = r_c400 - YW'(400);
                end
            end
            OP_DOY: begin
                n_t = TW'(dad_dbm(r_mon)) + TW'((r_mon >= 4'd2) && leap_cur)
                      + TW'(r_day) - TW'(1);
            end
            OP_ADDOFS: begin
                n_t = r_t + TW'(r_ofs);
            end
            OP_YSTEP: begin
                if (go_dn) begin
                    n_t    = r_t + ylen_prev;
                    n_year = r_year - YW'(1);
                    n_c400 = YW'(c_prev);
                end else if (go_up) begin
                    n_t    = r_t - ylen;
                    n_year = r_year + YW'(1);
                    n_c400 = YW'(c_next);
                end
            end
            OP_FLAGS: begin
                n_under = under_c;
                n_over  = over_c;
                n_mon   = 4'd0;
            end
            OP_MSTEP: begin
                if (m_move) begin
                    n_t   = r_t - mlen_s;
                    n_mon = r_mon + 4'd1;
                end
            end
            OP_EMIT: begin
                if (!o_busy) begin
                    n_o_valid = 1'b1;
                    if (r_under) begin
                        n_o_year  = 14'd1;
                        n_o_month = 4'd1;
                        n_o_day   = 5'd1;
                        n_o_ovf   = 1'b1;
                    end else if (r_over) begin
                        n_o_year  = YMAX_14;
                        n_o_month = 4'd12;
                        n_o_day   = 5'd31;
                        n_o_ovf   = 1'b1;
                    end else begin
                        n_o_year  = r_year[13:0];
                        n_o_month = r_mon + 4'd1;
                        n_o_day   = r_t[4:0] + 5'd1;
                        n_o_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_t = r_t;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= PC_WAIT;
            r_o_valid <= 1'b0;
        end else begin
            r_pc      <= n_pc;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_year    <= n_year;
        r_c400    <= n_c400;
        r_mon     <= n_mon;
        r_day     <= n_day;
        r_ofs     <= n_ofs;
        r_t       <= n_t;
        r_under   <= n_under;
        r_over    <= n_over;
        r_o_year  <= n_o_year;
        r_o_month <= n_o_month;
        r_o_day   <= n_o_day;
        r_o_ovf   <= n_o_ovf;
    end

    assign o_valid         = r_o_valid;
    assign o_result_year   = r_o_year;
    assign o_result_month  = r_o_month;
    assign o_result_day    = r_o_day;
    assign o_year_overflow = r_o_ovf;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_pc == PC_MOD400))
        else $error("accepted item did not start the program");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |=> r_o_valid)
        else $error("stalled result dropped");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_EMIT) |-> !(r_under && r_over))
        else $error("underflow and overflow both set");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_MSTEP) |-> (r_mon < 4'd12) && !t_neg)
        else $error("month walk out of range");

endmodule

`default_nettype wire
